// ===== rtl/shanc_pkg.sv =====
// Shared types, constants and SHA-256 round functions for the midstate nonce checker.
// No dependencies; used by every module in rtl/.
package shanc_pkg;

  typedef logic [31:0] word_t;
  // Working variables, index 0 is a, index 7 is h.
  typedef word_t [7:0] state_t;

  // Payload carried from one round stage to the next.
  // w[j] holds message word (round + j) for the round this stage performs.
  typedef struct packed {
    word_t [15:0] w;
    state_t       v;
    word_t        nonce;
  } stage_t;

  // Values derived from configuration, fixed for every nonce.
  typedef struct packed {
    word_t  w0;
    word_t  w1;
    word_t  w2;
    word_t  w16;
    word_t  w17;
    state_t v;    // a..h after round 2
  } baked_t;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegMid01  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMid23  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMid45  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMid67  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTail01 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTail2  = 3'd5;

  localparam int unsigned FirstRound = 3;
  localparam int unsigned LastRound  = 60;
  localparam int unsigned NumStages  = LastRound - FirstRound + 1;

  localparam word_t       PadWord    = 32'h8000_0000;
  localparam word_t       LenWord    = 32'd640;
  localparam logic [15:0] HitPattern = 16'h32E7;

  localparam word_t RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic word_t ssig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t bsig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t chf(word_t e, word_t f, word_t g);
    return g ^ (e & (f ^ g));
  endfunction

  function automatic word_t majf(word_t a, word_t b, word_t c);
    return (a & b) | (c & (a | b));
  endfunction

  function automatic word_t bswap(word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // w[t] from w[t-2], w[t-7], w[t-15], w[t-16]
  function automatic word_t sched_f(word_t wm2, word_t wm7, word_t wm15, word_t wm16);
    return ssig1(wm2) + wm7 + ssig0(wm15) + wm16;
  endfunction

  function automatic state_t round_f(state_t s, word_t k, word_t w);
    word_t  t1;
    word_t  t2;
    state_t r;
    t1   = s[7] + bsig1(s[4]) + chf(s[4], s[5], s[6]) + k + w;
    t2   = bsig0(s[0]) + majf(s[0], s[1], s[2]);
    r[7] = s[6];
    r[6] = s[5];
    r[5] = s[4];
    r[4] = s[3] + t1;
    r[3] = s[2];
    r[2] = s[1];
    r[1] = s[0];
    r[0] = t1 + t2;
    return r;
  endfunction

endpackage

// ===== rtl/sha256_midstate_nonce_check.sv =====
// Top level of the SHA-256 midstate nonce checker: entry stage, 58 round stages, output.
// Depends on shanc_pkg, shanc_bake, shanc_stage and shanc_out.
//
// Usage:
//   Configuration channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i) loads the
//   midstate and the first three tail words; cfg_ready_o is always high. Index 0..3 are
//   the midstate word pairs, 4 tail words 0/1, 5 tail word 2; other indices are ignored.
//   Write configuration only while no request is in flight.
//   After reset and after every write to index 0..5 the block precomputes rounds 0..2 and
//   W16/W17 with in_ready_o low; then in_ready_o rises.
//   Input channel (in_valid_i / in_ready_o, nonce_i): one nonce request per ready cycle.
//   Output channel (out_valid_o / out_ready_i, nonce_echo_o, hit_o): one result per
//   request, in order. hit_o is set when the low 16 bits of e after round 60 are 0x32E7.
//   Path: a nonce accepted on the input passes the entry register, one register per
//   round 3..60 and the output register before it is offered on the output.
//   Throughput: one nonce per cycle while nothing stalls; the rate is set by the fully
//   unrolled round pipeline, one round and one schedule word per stage.
//   Stall: the output has a register plus one skid slot. When the receiver holds off, one
//   more result lands in the skid slot, then the whole pipeline freezes and in_ready_o
//   drops until the skid slot drains. Nothing is lost or repeated.
module sha256_midstate_nonce_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [shanc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [31:0]                    nonce_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    nonce_echo_o,
  output logic                           hit_o
);

  localparam int unsigned NumStages = shanc_pkg::NumStages;

  logic                 busy;
  shanc_pkg::baked_t    baked;
  logic                 en;
  logic                 in_acc;

  // Entry register, holds the nonce, the state after round 2 and the window w3..w18
  logic                 ent_valid_q;
  shanc_pkg::stage_t    ent_data_q;
  shanc_pkg::stage_t    ent_data_d;
  shanc_pkg::word_t     w3;

  logic [NumStages:0]   st_valid;
  shanc_pkg::stage_t    st_data [NumStages+1];

  shanc_bake u_bake (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .baked_o     (baked)
  );

  // whole pipeline advances together; only the skid slot can stop it
  assign in_ready_o = en && !busy;
  assign in_acc     = in_valid_i && in_ready_o;
  assign w3         = shanc_pkg::bswap(nonce_i);

  always_comb begin
    ent_data_d.nonce = nonce_i;
    ent_data_d.v     = baked.v;
    ent_data_d.w     = '0;          // words 5..14 are zero
    ent_data_d.w[0]  = w3;
    ent_data_d.w[1]  = shanc_pkg::PadWord;
    ent_data_d.w[12] = shanc_pkg::LenWord;
    ent_data_d.w[13] = baked.w16;
    ent_data_d.w[14] = baked.w17;
    // w18: w11 is zero
    ent_data_d.w[15] = shanc_pkg::ssig1(baked.w16) + shanc_pkg::ssig0(w3) + baked.w2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (en) begin
      ent_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_data_q <= ent_data_d;
    end
  end

  assign st_valid[0] = ent_valid_q;
  assign st_data[0]  = ent_data_q;

  // Stage g performs round FirstRound + g
  for (genvar g = 0; g < NumStages; g++) begin : g_round
    shanc_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .k_i     (shanc_pkg::RoundK[shanc_pkg::FirstRound + g]),
      .valid_i (st_valid[g]),
      .data_i  (st_data[g]),
      .valid_o (st_valid[g+1]),
      .data_o  (st_data[g+1])
    );
  end

  shanc_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .last_valid_i (st_valid[NumStages]),
    .last_nonce_i (st_data[NumStages].nonce),
    .last_e_i     (st_data[NumStages].v[4]),
    .out_ready_i  (out_ready_i),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .nonce_echo_o (nonce_echo_o),
    .hit_o        (hit_o)
  );

endmodule

// ===== rtl/shanc_bake.sv =====
// Configuration registers and the precompute sequencer (rounds 0..2, W16, W17).
// Depends on shanc_pkg.
module shanc_bake (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [shanc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [63:0]                      cfg_data_i,
  output logic                             busy_o,
  output shanc_pkg::baked_t                baked_o
);

  logic [3:0][63:0]      mid_q;
  logic [63:0]           tail01_q;
  logic [31:0]           tail2_q;
  logic                  busy_q;
  logic [1:0]            cnt_q;
  shanc_pkg::state_t     v_q;
  shanc_pkg::word_t      w16_q;
  shanc_pkg::word_t      w17_q;

  logic                  rebake;
  shanc_pkg::word_t      w0;
  shanc_pkg::word_t      w1;
  shanc_pkg::word_t      w2;
  shanc_pkg::word_t      k_sel;
  shanc_pkg::word_t      w_sel;
  shanc_pkg::state_t     mid_state;

  assign cfg_ready_o = 1'b1;
  assign rebake      = cfg_valid_i && (cfg_index_i <= shanc_pkg::RegTail2);

  assign w0 = tail01_q[63:32];
  assign w1 = tail01_q[31:0];
  assign w2 = tail2_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mid_state[2*i]   = mid_q[i][63:32];
      mid_state[2*i+1] = mid_q[i][31:0];
    end
  end

  // cnt 1..3 runs rounds 0..2
  always_comb begin
    case (cnt_q)
      2'd1: begin
        k_sel = shanc_pkg::RoundK[0];
        w_sel = w0;
      end
      2'd2: begin
        k_sel = shanc_pkg::RoundK[1];
        w_sel = w1;
      end
      default: begin
        k_sel = shanc_pkg::RoundK[2];
        w_sel = w2;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q    <= '0;
      tail01_q <= '0;
      tail2_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        shanc_pkg::RegMid01:  mid_q[0] <= cfg_data_i;
        shanc_pkg::RegMid23:  mid_q[1] <= cfg_data_i;
        shanc_pkg::RegMid45:  mid_q[2] <= cfg_data_i;
        shanc_pkg::RegMid67:  mid_q[3] <= cfg_data_i;
        shanc_pkg::RegTail01: tail01_q <= cfg_data_i;
        shanc_pkg::RegTail2:  tail2_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // reset also forces a pass so the derived values match the zeroed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd0;
    end else if (rebake) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !rebake) begin
      if (cnt_q == 2'd0) begin
        v_q   <= mid_state;
        w16_q <= shanc_pkg::ssig0(w1) + w0;
        w17_q <= shanc_pkg::ssig1(shanc_pkg::LenWord) + shanc_pkg::ssig0(w2) + w1;
      end else begin
        v_q <= shanc_pkg::round_f(v_q, k_sel, w_sel);
      end
    end
  end

  assign busy_o      = busy_q;
  assign baked_o.w0  = w0;
  assign baked_o.w1  = w1;
  assign baked_o.w2  = w2;
  assign baked_o.w16 = w16_q;
  assign baked_o.w17 = w17_q;
  assign baked_o.v   = v_q;

endmodule

// ===== rtl/shanc_stage.sv =====
// One pipeline stage: a SHA-256 round plus one step of the message schedule.
// Depends on shanc_pkg.
module shanc_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  shanc_pkg::word_t    k_i,
  input  logic                valid_i,
  input  shanc_pkg::stage_t   data_i,
  output logic                valid_o,
  output shanc_pkg::stage_t   data_o
);

  logic               valid_q;
  shanc_pkg::stage_t  data_q;
  shanc_pkg::stage_t  data_d;

  always_comb begin
    data_d.nonce = data_i.nonce;
    data_d.v     = shanc_pkg::round_f(data_i.v, k_i, data_i.w[0]);
    // slide the window by one word, new word enters at the top
    data_d.w     = {shanc_pkg::sched_f(data_i.w[14], data_i.w[9], data_i.w[1], data_i.w[0]),
                    data_i.w[15:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/shanc_out.sv =====
// Hit compare, output register and skid slot; produces the pipeline advance enable.
// Depends on shanc_pkg.
module shanc_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               last_valid_i,
  input  shanc_pkg::word_t   last_nonce_i,
  input  shanc_pkg::word_t   last_e_i,
  input  logic               out_ready_i,
  output logic               en_o,
  output logic               out_valid_o,
  output logic [31:0]        nonce_echo_o,
  output logic               hit_o
);

  logic         out_valid_q;
  logic [31:0]  out_nonce_q;
  logic         out_hit_q;
  logic         skid_valid_q;
  logic [31:0]  skid_nonce_q;
  logic         skid_hit_q;

  logic         take;
  logic         incoming;
  logic         last_hit;

  assign en_o     = !skid_valid_q;
  assign take     = out_valid_q && out_ready_i;
  assign incoming = last_valid_i && en_o;
  assign last_hit = (last_e_i[15:0] == shanc_pkg::HitPattern);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (incoming) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_nonce_q <= skid_nonce_q;
        out_hit_q   <= skid_hit_q;
      end
    end else if (incoming) begin
      if (out_valid_q && !take) begin
        skid_nonce_q <= last_nonce_i;
        skid_hit_q   <= last_hit;
      end else begin
        out_nonce_q <= last_nonce_i;
        out_hit_q   <= last_hit;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign nonce_echo_o = out_nonce_q;
  assign hit_o        = out_hit_q;

endmodule

// ===== rtl/shanc_checker.sv =====
// Port-level checks for sha256_midstate_nonce_check, attached with bind.
// Depends on shanc_pkg.
module shanc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [shanc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic                           in_ready_o,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [31:0]                    nonce_echo_o,
  input  logic                           hit_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // the skid path must not disturb the offered result
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(nonce_echo_o) && $stable(hit_o))
    else $error("result changed while stalled");

  // a register write restarts precompute, which blocks new nonces
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i <= shanc_pkg::RegTail2) |=> !in_ready_o)
    else $error("nonce accepted during precompute");

endmodule

bind sha256_midstate_nonce_check shanc_checker u_shanc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .cfg_index_i  (cfg_index_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .nonce_echo_o (nonce_echo_o),
  .hit_o        (hit_o)
);
